/* src/evg_pkg.sv */
`default_nettype none
package evg_pkg;

  localparam int IDX_W             = 16;
  localparam int PHASE_W           = 32;
  localparam int QUO_W             = IDX_W + PHASE_W;
  localparam int COORD_W           = 32;
  localparam int TRIG_W            = 32;
  localparam int ANG_W             = 32;
  localparam int PROD_W            = COORD_W + TRIG_W;
  localparam int ATAN_ENTRIES      = 30;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int CFG_ADDR_W        = 3;

  localparam logic signed [TRIG_W-1:0] GAIN_Q30 = 32'sd652032874;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_CENTER_X     = 3'd0,
    REG_CENTER_Y     = 3'd1,
    REG_CENTER_Z     = 3'd2,
    REG_MAJOR_RADIUS = 3'd3,
    REG_MINOR_RADIUS = 3'd4,
    REG_VERTEX_COUNT = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    QUAD_FIRST  = 2'd0,
    QUAD_SECOND = 2'd1,
    QUAD_THIRD  = 2'd2,
    QUAD_FOURTH = 2'd3
  } quad_t;

  typedef struct packed {
    logic  vld;
    logic  last;
    logic  err;
    quad_t quad;
  } ctl_t;

  // atan(2^-k) in units of 2^-32 turn
  function automatic logic signed [ANG_W-1:0] atan_turn(input int k);
    logic signed [ANG_W-1:0] a;
    case (k)
      0:  a = 32'sd536870912;
      1:  a = 32'sd316933406;
      2:  a = 32'sd167458907;
      3:  a = 32'sd85004756;
      4:  a = 32'sd42667331;
      5:  a = 32'sd21354465;
      6:  a = 32'sd10679838;
      7:  a = 32'sd5340245;
      8:  a = 32'sd2670163;
      9:  a = 32'sd1335087;
      10: a = 32'sd667544;
      11: a = 32'sd333772;
      12: a = 32'sd166886;
      13: a = 32'sd83443;
      14: a = 32'sd41722;
      15: a = 32'sd20861;
      16: a = 32'sd10430;
      17: a = 32'sd5215;
      18: a = 32'sd2608;
      19: a = 32'sd1304;
      20: a = 32'sd652;
      21: a = 32'sd326;
      22: a = 32'sd163;
      23: a = 32'sd81;
      24: a = 32'sd41;
      25: a = 32'sd20;
      26: a = 32'sd10;
      27: a = 32'sd5;
      28: a = 32'sd3;
      29: a = 32'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

/* src/evg_div_cell.sv */
`default_nettype none
module evg_div_cell
  import evg_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             adv,
  input  wire logic [IDX_W-1:0] den,
  input  wire ctl_t             ctl_i,
  input  wire logic [IDX_W-1:0] a_i,
  input  wire logic [QUO_W-1:0] q_i,
  output ctl_t                  ctl_o,
  output logic      [IDX_W-1:0] a_o,
  output logic      [QUO_W-1:0] q_o
);

  ctl_t             ctl_r;
  logic [IDX_W-1:0] a_r, a_nxt;
  logic [QUO_W-1:0] q_r, q_nxt;
  logic [IDX_W:0]   sh;
  logic [IDX_W:0]   diff;
  logic             ge;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    sh    = {a_i, q_i[QUO_W-1]};
    diff  = sh - {1'b0, den};
    ge    = (sh >= {1'b0, den});
    a_nxt = ge ? diff[IDX_W-1:0] : sh[IDX_W-1:0];
    q_nxt = {q_i[QUO_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r <= a_nxt;
      q_r <= q_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign a_o   = a_r;
  assign q_o   = q_r;

endmodule
`default_nettype wire

/* src/evg_cordic_cell.sv */
`default_nettype none
module evg_cordic_cell
  import evg_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     adv,
  input  wire ctl_t                     ctl_i,
  input  wire logic signed [TRIG_W-1:0] x_i,
  input  wire logic signed [TRIG_W-1:0] y_i,
  input  wire logic signed [ANG_W-1:0]  z_i,
  output ctl_t                          ctl_o,
  output logic signed      [TRIG_W-1:0] x_o,
  output logic signed      [TRIG_W-1:0] y_o,
  output logic signed      [ANG_W-1:0]  z_o
);

  localparam logic signed [ANG_W-1:0] ATAN = atan_turn(STAGE);

  ctl_t                     ctl_r;
  logic signed [TRIG_W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [ANG_W-1:0]  z_r, z_nxt;
  logic signed [TRIG_W-1:0] dx, dy;

  always_comb begin
    dx = y_i >>> STAGE;
    dy = x_i >>> STAGE;
    if (!z_i[ANG_W-1]) begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      z_nxt = z_i - ATAN;
    end else begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      z_nxt = z_i + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;

endmodule
`default_nettype wire

/* src/evg_scale.sv */
`default_nettype none
module evg_scale
  import evg_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      adv,
  input  wire ctl_t                      ctl_i,
  input  wire logic signed [TRIG_W-1:0]  x_i,
  input  wire logic signed [TRIG_W-1:0]  y_i,
  input  wire logic signed [COORD_W-1:0] center_x,
  input  wire logic signed [COORD_W-1:0] center_y,
  input  wire logic signed [COORD_W-1:0] major_radius,
  input  wire logic signed [COORD_W-1:0] minor_radius,
  output ctl_t                           ctl_o,
  output logic signed      [COORD_W-1:0] px_o,
  output logic signed      [COORD_W-1:0] py_o,
  output logic                           sat_o
);

  localparam int RND_W = PROD_W - 30;
  localparam int SUM_W = RND_W + 1;
  localparam logic signed [PROD_W-1:0] HALF = 64'sd536870912;
  localparam logic signed [COORD_W-1:0] MAX_V = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] MIN_V = {1'b1, {(COORD_W-1){1'b0}}};

  ctl_t                     ctl1_r, ctl2_r, ctl3_r;
  logic signed [TRIG_W-1:0] c_r, c_nxt, s_r, s_nxt;
  logic signed [PROD_W-1:0] px_prod_r, px_prod_nxt, py_prod_r, py_prod_nxt;
  logic signed [COORD_W-1:0] px_r, px_nxt, py_r, py_nxt;
  logic                      sat_r, sat_nxt;
  logic signed [PROD_W-1:0]  rx_full, ry_full;
  logic signed [SUM_W-1:0]   sum_x, sum_y;
  logic                      ovf_x, ovf_y;

  // quadrant fold
  always_comb begin
    case (ctl_i.quad)
      QUAD_FIRST: begin
        c_nxt = x_i;
        s_nxt = y_i;
      end
      QUAD_SECOND: begin
        c_nxt = -y_i;
        s_nxt = x_i;
      end
      QUAD_THIRD: begin
        c_nxt = -x_i;
        s_nxt = -y_i;
      end
      default: begin
        c_nxt = y_i;
        s_nxt = -x_i;
      end
    endcase
  end

  always_comb begin
    px_prod_nxt = major_radius * c_r;
    py_prod_nxt = minor_radius * s_r;
  end

  // round half up to Q16.16, add center, clamp
  always_comb begin
    rx_full = (px_prod_r + HALF) >>> 30;
    ry_full = (py_prod_r + HALF) >>> 30;
    sum_x   = {{(SUM_W-COORD_W){center_x[COORD_W-1]}}, center_x}
            + {rx_full[RND_W-1], rx_full[RND_W-1:0]};
    sum_y   = {{(SUM_W-COORD_W){center_y[COORD_W-1]}}, center_y}
            + {ry_full[RND_W-1], ry_full[RND_W-1:0]};
    ovf_x   = (sum_x[SUM_W-1:COORD_W-1] != {(SUM_W-COORD_W+1){sum_x[COORD_W-1]}});
    ovf_y   = (sum_y[SUM_W-1:COORD_W-1] != {(SUM_W-COORD_W+1){sum_y[COORD_W-1]}});
    px_nxt  = ovf_x ? (sum_x[SUM_W-1] ? MIN_V : MAX_V) : sum_x[COORD_W-1:0];
    py_nxt  = ovf_y ? (sum_y[SUM_W-1] ? MIN_V : MAX_V) : sum_y[COORD_W-1:0];
    sat_nxt = ovf_x | ovf_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
    end else if (adv) begin
      ctl1_r <= ctl_i;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_r       <= c_nxt;
      s_r       <= s_nxt;
      px_prod_r <= px_prod_nxt;
      py_prod_r <= py_prod_nxt;
      px_r      <= px_nxt;
      py_r      <= py_nxt;
      sat_r     <= sat_nxt;
    end
  end

  assign ctl_o = ctl3_r;
  assign px_o  = px_r;
  assign py_o  = py_r;
  assign sat_o = sat_r;

endmodule
`default_nettype wire

/* src/ellipse_vertex_generator_top.sv */
// Ellipse vertex generator.
// Input channel: in_valid / in_stall with one vertex index per word. A word
// is taken on a rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with point x, y, z (Q16.16) and the
// last_vertex, index_error and saturated flags; one result word per input.
// Configuration: cfg_we writes cfg_wdata into register cfg_addr (center x,
// y, z, major radius, minor radius, vertex count); write only while idle.
// The phase is formed in the restoring divider chain, which yields one
// quotient bit per cell; then come one CORDIC cell per stage, the quadrant
// fold, the multiply and the round/clamp.
// Throughput is one word per cycle unless held; the chain advances together.
// While out_valid is high and out_stall is high the chain holds and
// in_stall is raised; the output word stays stable.
// Synchronous reset empties the chain and loads the default registers
// (unit circle scaled to 1.0 x 0.5, 21 vertices).
`default_nettype none
module ellipse_vertex_generator_top
  import evg_pkg::*;
#(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [IDX_W-1:0]          in_vertex_index,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic signed [COORD_W-1:0]      out_point_x,
  output logic signed [COORD_W-1:0]      out_point_y,
  output logic signed [COORD_W-1:0]      out_point_z,
  output logic                           out_last_vertex,
  output logic                           out_index_error,
  output logic                           out_saturated,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_ADDR_W-1:0]     cfg_addr,
  input  wire logic [COORD_W-1:0]        cfg_wdata
);

  localparam int NST = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;

  logic signed [COORD_W-1:0] center_x_r, center_y_r, center_z_r;
  logic signed [COORD_W-1:0] major_r, minor_r;
  logic        [IDX_W-1:0]   count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      center_z_r <= '0;
      major_r    <= 32'sd65536;
      minor_r    <= 32'sd32768;
      count_r    <= 16'd21;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_CENTER_X:     center_x_r <= cfg_wdata;
        REG_CENTER_Y:     center_y_r <= cfg_wdata;
        REG_CENTER_Z:     center_z_r <= cfg_wdata;
        REG_MAJOR_RADIUS: major_r    <= cfg_wdata;
        REG_MINOR_RADIUS: minor_r    <= cfg_wdata;
        REG_VERTEX_COUNT: count_r    <= cfg_wdata[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  logic [IDX_W-1:0] den;
  logic             adv;
  ctl_t             in_ctl;

  assign den      = (count_r < 16'd2) ? 16'd1 : (count_r - 16'd1);
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  always_comb begin
    in_ctl      = '0;
    in_ctl.vld  = in_valid;
    in_ctl.last = (in_vertex_index == den);
    in_ctl.err  = (in_vertex_index > den);
    in_ctl.quad = QUAD_FIRST;
  end

  // phase divider chain
  ctl_t             div_ctl [0:QUO_W];
  logic [IDX_W-1:0] div_a   [0:QUO_W];
  logic [QUO_W-1:0] div_q   [0:QUO_W];

  assign div_ctl[0] = in_ctl;
  assign div_a[0]   = '0;
  assign div_q[0]   = {in_vertex_index, {PHASE_W{1'b0}}};

  for (genvar i = 0; i < QUO_W; i++) begin : g_div
    evg_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .den   (den),
      .ctl_i (div_ctl[i]),
      .a_i   (div_a[i]),
      .q_i   (div_q[i]),
      .ctl_o (div_ctl[i+1]),
      .a_o   (div_a[i+1]),
      .q_o   (div_q[i+1])
    );
  end

  // CORDIC chain
  logic [PHASE_W-1:0]       phase;
  ctl_t                     cor_ctl_first;
  ctl_t                     cor_ctl [0:NST];
  logic signed [TRIG_W-1:0] cor_x   [0:NST];
  logic signed [TRIG_W-1:0] cor_y   [0:NST];
  logic signed [ANG_W-1:0]  cor_z   [0:NST];

  assign phase = div_q[QUO_W][PHASE_W-1:0];

  always_comb begin
    cor_ctl_first      = div_ctl[QUO_W];
    cor_ctl_first.quad = quad_t'(phase[PHASE_W-1:PHASE_W-2]);
  end

  assign cor_ctl[0] = cor_ctl_first;
  assign cor_x[0]   = GAIN_Q30;
  assign cor_y[0]   = '0;
  assign cor_z[0]   = {2'b00, phase[PHASE_W-3:0]};

  for (genvar k = 0; k < NST; k++) begin : g_cor
    evg_cordic_cell #(
      .STAGE (k)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .ctl_i (cor_ctl[k]),
      .x_i   (cor_x[k]),
      .y_i   (cor_y[k]),
      .z_i   (cor_z[k]),
      .ctl_o (cor_ctl[k+1]),
      .x_o   (cor_x[k+1]),
      .y_o   (cor_y[k+1]),
      .z_o   (cor_z[k+1])
    );
  end

  ctl_t out_ctl;

  evg_scale u_scale (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .ctl_i        (cor_ctl[NST]),
    .x_i          (cor_x[NST]),
    .y_i          (cor_y[NST]),
    .center_x     (center_x_r),
    .center_y     (center_y_r),
    .major_radius (major_r),
    .minor_radius (minor_r),
    .ctl_o        (out_ctl),
    .px_o         (out_point_x),
    .py_o         (out_point_y),
    .sat_o        (out_saturated)
  );

  assign out_valid       = out_ctl.vld;
  assign out_last_vertex = out_ctl.last;
  assign out_index_error = out_ctl.err;
  assign out_point_z     = center_z_r;

endmodule
`default_nettype wire

/* bench/ellipse_vertex_generator_top_test.sv */
module ellipse_vertex_generator_top_test;
  import evg_pkg::*;

  localparam int STAGES = (CORDIC_STAGES_DEF < ATAN_ENTRIES) ? CORDIC_STAGES_DEF : ATAN_ENTRIES;
  localparam int DRAIN_CYCLES = 51 + CORDIC_STAGES_DEF + 16;
  localparam longint INT32_MAX = 64'sd2147483647;
  localparam longint INT32_MIN = -64'sd2147483648;
  localparam longint HALF_LSB_Q30 = 64'sd536870912;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_B = 3'd7;
  localparam logic [COORD_W-1:0] Q_MAX = 32'h7fff_ffff;
  localparam logic [COORD_W-1:0] Q_MIN = 32'h8000_0000;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      last;
    logic                      err;
    logic                      sat;
  } vertex_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_SPARSE,
    STALL_PERIODIC,
    STALL_HEAVY
  } stall_mode_t;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic [IDX_W-1:0]           in_vertex_index;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [COORD_W-1:0]  out_point_x;
  logic signed [COORD_W-1:0]  out_point_y;
  logic signed [COORD_W-1:0]  out_point_z;
  logic                       out_last_vertex;
  logic                       out_index_error;
  logic                       out_saturated;
  logic                       cfg_we;
  logic [CFG_ADDR_W-1:0]      cfg_addr;
  logic [COORD_W-1:0]         cfg_wdata;

  // atan(2^-k) in 2^-32 turn
  longint atan_steps [ATAN_ENTRIES] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1
  };

  logic signed [COORD_W-1:0]  ctr_x;
  logic signed [COORD_W-1:0]  ctr_y;
  logic signed [COORD_W-1:0]  ctr_z;
  logic signed [COORD_W-1:0]  rad_major;
  logic signed [COORD_W-1:0]  rad_minor;
  logic [IDX_W-1:0]           n_vertices;

  vertex_t                    pending_vertices[$];
  vertex_t                    got_word;
  vertex_t                    want_word;
  int                         mismatches;
  int                         burst_left;
  bit                         sender_steady;
  stall_mode_t                stall_mode = STALL_NONE;
  int                         stall_left = 0;
  int                         stall_tick = 0;

  ellipse_vertex_generator_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_vertex_index (in_vertex_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_point_x     (out_point_x),
    .out_point_y     (out_point_y),
    .out_point_z     (out_point_z),
    .out_last_vertex (out_last_vertex),
    .out_index_error (out_index_error),
    .out_saturated   (out_saturated),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata)
  );

  function automatic logic signed [COORD_W-1:0] clamp_axis(input longint center,
                                                           input longint radius,
                                                           input longint trig,
                                                           output bit clipped);
    longint sum;
    clipped = 1'b0;
    sum = center + ((radius * trig + HALF_LSB_Q30) >>> 30);
    if (sum > INT32_MAX) begin
      clipped = 1'b1;
      sum = INT32_MAX;
    end else if (sum < INT32_MIN) begin
      clipped = 1'b1;
      sum = INT32_MIN;
    end
    return sum[COORD_W-1:0];
  endfunction

  function automatic vertex_t ellipse_point(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] span;
    logic [QUO_W-1:0] quo;
    quad_t            quad;
    longint           ang;
    longint           vx;
    longint           vy;
    longint           dx;
    longint           dy;
    longint           c;
    longint           s;
    bit               clip_x;
    bit               clip_y;
    int               k;
    vertex_t          v;
    span = (n_vertices < 2) ? IDX_W'(1) : n_vertices - 1'b1;
    quo = {idx, {PHASE_W{1'b0}}} / QUO_W'(span);
    quad = quad_t'(quo[PHASE_W-1:PHASE_W-2]);
    ang = {34'b0, quo[PHASE_W-3:0]};
    vx = longint'(GAIN_Q30);
    vy = 0;
    for (k = 0; k < STAGES; k++) begin
      dx = vy >>> k;
      dy = vx >>> k;
      if (ang >= 0) begin
        vx = vx - dx;
        vy = vy + dy;
        ang = ang - atan_steps[k];
      end else begin
        vx = vx + dx;
        vy = vy - dy;
        ang = ang + atan_steps[k];
      end
    end
    case (quad)
      QUAD_FIRST: begin
        c = vx;
        s = vy;
      end
      QUAD_SECOND: begin
        c = -vy;
        s = vx;
      end
      QUAD_THIRD: begin
        c = -vx;
        s = -vy;
      end
      default: begin
        c = vy;
        s = -vx;
      end
    endcase
    v.x = clamp_axis(longint'(ctr_x), longint'(rad_major), c, clip_x);
    v.y = clamp_axis(longint'(ctr_y), longint'(rad_minor), s, clip_y);
    v.z = ctr_z;
    v.last = (idx == span);
    v.err = (idx > span);
    v.sat = clip_x | clip_y;
    return v;
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    logic [COORD_W-1:0] r;
    r = $urandom;
    case ($urandom_range(0, 5))
      0: return r;
      1: return Q_MAX;
      2: return Q_MIN;
      default: return {{12{r[19]}}, r[19:0]};
    endcase
  endfunction

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [COORD_W-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_addr = addr;
    cfg_wdata = data;
    case (addr)
      REG_CENTER_X:     ctr_x = data;
      REG_CENTER_Y:     ctr_y = data;
      REG_CENTER_Z:     ctr_z = data;
      REG_MAJOR_RADIUS: rad_major = data;
      REG_MINOR_RADIUS: rad_minor = data;
      REG_VERTEX_COUNT: n_vertices = data[IDX_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_index(input logic [IDX_W-1:0] idx);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = sender_steady ? 1000 : $urandom_range(1, 24);
      gap = sender_steady ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid = 1'b1;
    in_vertex_index = idx;
    do @(posedge clk); while (in_stall);
    pending_vertices.push_back(ellipse_point(idx));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    burst_left = 0;
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_default_setup();
    send_index(16'd0);
    send_index(16'd20);
    send_index(16'd21);
    send_index(16'hffff);
  endtask

  task automatic test_quadrants();
    int i;
    wait_idle();
    cfg_write(REG_VERTEX_COUNT, 32'd9);
    cfg_write(REG_CENTER_X, 32'h0003_8000);
    cfg_write(REG_CENTER_Y, 32'hfffe_0000);
    cfg_write(REG_CENTER_Z, 32'h1234_5678);
    cfg_write(REG_MAJOR_RADIUS, 32'h0002_4000);
    cfg_write(REG_MINOR_RADIUS, 32'hffff_0000);
    for (i = 0; i < 9; i++) send_index(IDX_W'(i));
  endtask

  // counts of 0 and 1 behave as a divisor of one
  task automatic test_small_counts();
    wait_idle();
    cfg_write(REG_VERTEX_COUNT, 32'd0);
    send_index(16'd0);
    send_index(16'd1);
    wait_idle();
    cfg_write(REG_VERTEX_COUNT, 32'd1);
    send_index(16'hffff);
    wait_idle();
    cfg_write(REG_VERTEX_COUNT, 32'd2);
    send_index(16'd1);
    send_index(16'd2);
  endtask

  task automatic test_saturation();
    wait_idle();
    cfg_write(REG_VERTEX_COUNT, 32'hffff_ffff);
    cfg_write(REG_CENTER_X, Q_MAX);
    cfg_write(REG_MAJOR_RADIUS, Q_MAX);
    cfg_write(REG_CENTER_Y, Q_MIN);
    cfg_write(REG_MINOR_RADIUS, Q_MAX);
    cfg_write(REG_CENTER_Z, Q_MIN);
    send_index(16'd0);
    send_index(16'd49151);
    send_index(16'd65534);
    send_index(16'd65535);
    wait_idle();
    cfg_write(REG_VERTEX_COUNT, 32'd5);
    cfg_write(REG_CENTER_X, Q_MIN);
    cfg_write(REG_MAJOR_RADIUS, Q_MIN);
    send_index(16'd0);
    send_index(16'd2);
  endtask

  // writes to unmapped indexes must leave every register alone
  task automatic test_spare_registers();
    wait_idle();
    cfg_write(REG_SPARE_A, 32'hffff_ffff);
    cfg_write(REG_SPARE_B, 32'hffff_ffff);
    send_index(16'd1);
  endtask

  task automatic test_random_vertices();
    int phase;
    int i;
    int span;
    logic [COORD_W-1:0] r;
    logic [IDX_W-1:0] idx;
    for (phase = 0; phase < 12; phase++) begin
      wait_idle();
      sender_steady = ($urandom_range(0, 3) == 0);
      cfg_write(REG_CENTER_X, rand_coord());
      cfg_write(REG_CENTER_Y, rand_coord());
      cfg_write(REG_CENTER_Z, rand_coord());
      cfg_write(REG_MAJOR_RADIUS, rand_coord());
      cfg_write(REG_MINOR_RADIUS, rand_coord());
      r = $urandom;
      case ($urandom_range(0, 7))
        0: r[IDX_W-1:0] = IDX_W'($urandom_range(0, 1));
        1: ;
        2: r[IDX_W-1:0] = 16'hffff;
        default: r[IDX_W-1:0] = IDX_W'($urandom_range(2, 40));
      endcase
      cfg_write(REG_VERTEX_COUNT, r);
      span = (n_vertices < 2) ? 1 : int'(n_vertices) - 1;
      for (i = 0; i < 80; i++) begin
        case ($urandom_range(0, 9))
          0: idx = IDX_W'($urandom_range(0, 65535));
          1: idx = IDX_W'(span);
          2: idx = IDX_W'(span + 1);
          default: idx = IDX_W'($urandom_range(0, span));
        endcase
        send_index(idx);
      end
    end
    sender_steady = 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("Simulation FAILED");
    $finish;
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall = 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        stall_left = $urandom_range(16, 160);
      end
      stall_left--;
      stall_tick++;
      case (stall_mode)
        STALL_NONE:     out_stall = 1'b0;
        STALL_SPARSE:   out_stall = ($urandom_range(0, 3) == 0);
        STALL_PERIODIC: out_stall = ((stall_tick % 7) < 3);
        default:        out_stall = ($urandom_range(0, 99) < 70);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      got_word = {out_point_x, out_point_y, out_point_z,
                  out_last_vertex, out_index_error, out_saturated};
      if (pending_vertices.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: x=%0d y=%0d z=%0d last=%0b err=%0b sat=%0b",
                   got_word.x, got_word.y, got_word.z,
                   got_word.last, got_word.err, got_word.sat);
      end else begin
        want_word = pending_vertices.pop_front();
        if (got_word !== want_word) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected x=%0d y=%0d z=%0d last=%0b err=%0b sat=%0b,",
                      " got x=%0d y=%0d z=%0d last=%0b err=%0b sat=%0b"},
                     want_word.x, want_word.y, want_word.z,
                     want_word.last, want_word.err, want_word.sat,
                     got_word.x, got_word.y, got_word.z,
                     got_word.last, got_word.err, got_word.sat);
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_vertex_index = '0;
    cfg_we = 1'b0;
    cfg_addr = REG_CENTER_X;
    cfg_wdata = '0;
    mismatches = 0;
    burst_left = 0;
    sender_steady = 1'b0;
    ctr_x = '0;
    ctr_y = '0;
    ctr_z = '0;
    rad_major = 32'sd65536;
    rad_minor = 32'sd32768;
    n_vertices = 16'd21;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_default_setup();
    test_quadrants();
    test_small_counts();
    test_saturation();
    test_spare_registers();
    test_random_vertices();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_vertices.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
